// ===== src/battery_charge_reading_qualifier_defines.svh =====
`ifndef BATTERY_CHARGE_READING_QUALIFIER_DEFINES_SVH
`define BATTERY_CHARGE_READING_QUALIFIER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define BCRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define BCRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bcrq_pkg.sv =====
`timescale 1ns / 1ps

package bcrq_pkg;

    localparam int RUN_COUNT_WIDTH_DEF = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int RUN_LEN_W   = 8;
    localparam int MV_W        = 16;
    localparam int WORD_W      = 16;
    localparam int PCT_W       = 8;
    localparam int MODE_W      = 2;

    localparam int S_TDATA_W = 40;   // read_good, charge_word, cell_millivolts, pad
    localparam int M_TDATA_W = 16;   // gauge_mode, shown_percent, changed, pad

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_RUN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOST_RUN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_MV   = 2'd2;

    localparam logic [RUN_LEN_W-1:0] READY_RUN_RST = 8'd3;
    localparam logic [RUN_LEN_W-1:0] LOST_RUN_RST  = 8'd3;
    localparam logic [MV_W-1:0]      ZERO_MV_RST   = 16'd3900;

    localparam logic [PCT_W-1:0]  PCT_MAX    = 8'd100;
    localparam logic [PCT_W-1:0]  PCT_NONE   = 8'hFF;
    localparam logic [WORD_W-1:0] WORD_EMPTY = 16'h0000;

    // Command on the input tuser
    localparam logic CMD_READING  = 1'b0;
    localparam logic CMD_FALLBACK = 1'b1;

    // Mode codes as seen on the output
    localparam logic [MODE_W-1:0] GM_WAIT     = 2'd0;
    localparam logic [MODE_W-1:0] GM_READY    = 2'd1;
    localparam logic [MODE_W-1:0] GM_FALLBACK = 2'd2;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'b001,
        ST_READY    = 3'b010,
        ST_FALLBACK = 3'b100
    } t_mode;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            ST_READY:    c = GM_READY;
            ST_FALLBACK: c = GM_FALLBACK;
            default:     c = GM_WAIT;
        endcase
        return c;
    endfunction

endpackage

// ===== src/battery_charge_reading_qualifier.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tuser: cmd; tdata: reading fields
// m_axis    out  m_axis_tvalid/tready    tdata: mode, shown percent, changed
// cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle sustained while m_axis_tready is high; m_axis_tvalid rises once an accepted
// item has passed the input register, then qualification and state update into the result register.
// The run counters and mode register are updated when an item moves from the
// input register to the result register.
// Reset is synchronous, active low; config returns to 3 / 3 / 3900 mV.
// A stalled m_axis holds both stages; s_axis_tready drops only when both are full.

`include "battery_charge_reading_qualifier_defines.svh"

module battery_charge_reading_qualifier
    import bcrq_pkg::*;
#(
    parameter int RUN_COUNT_WIDTH = RUN_COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [0] read_good, [16:1] charge_word,
                                                   // [32:17] cell_millivolts, [39:33] zero
    input  logic [0:0]             s_axis_tuser,   // [0] cmd

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [1:0] gauge_mode, [9:2] shown_percent,
                                                   // [10] changed, [15:11] zero

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int RW = RUN_COUNT_WIDTH;
    localparam int CW = (RW > RUN_LEN_W) ? RW : RUN_LEN_W;
    localparam logic [RW-1:0] RUN_MAX = {RW{1'b1}};

    // Configuration
    logic [RUN_LEN_W-1:0] r_ready_run_len;
    logic [RUN_LEN_W-1:0] r_lost_run_len;
    logic [MV_W-1:0]      r_zero_mv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_run_len <= READY_RUN_RST;
            r_lost_run_len  <= LOST_RUN_RST;
            r_zero_mv       <= ZERO_MV_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_READY_RUN: r_ready_run_len <= i_cfg_data[RUN_LEN_W-1:0];
                CFG_LOST_RUN:  r_lost_run_len  <= i_cfg_data[RUN_LEN_W-1:0];
                CFG_ZERO_MV:   r_zero_mv       <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic r_in_valid;
    logic r_out_valid;
    logic advance;
    logic in_accept;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    // Input register
    logic              r_in_cmd;
    logic              r_in_good;
    logic [WORD_W-1:0] r_in_word;
    logic [MV_W-1:0]   r_in_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd  <= s_axis_tuser[0];
            r_in_good <= s_axis_tdata[0];
            r_in_word <= s_axis_tdata[WORD_W:1];
            r_in_mv   <= s_axis_tdata[WORD_W+MV_W:WORD_W+1];
        end
    end

    // Qualification state
    t_mode             r_mode, n_mode;
    logic [RW-1:0]     r_good_run, n_good_run;
    logic [RW-1:0]     r_bad_run, n_bad_run;
    logic [PCT_W-1:0]  r_pct, n_pct;

    logic [PCT_W-1:0]  in_pct;
    logic              reading_ok;
    logic [RW-1:0]     good_inc;
    logic [RW-1:0]     bad_inc;
    logic              step;

    assign step   = r_in_valid && advance;
    assign in_pct = r_in_word[WORD_W-1:WORD_W-PCT_W];
    assign reading_ok = r_in_good && (in_pct <= PCT_MAX)
                        && !((r_in_word == WORD_EMPTY) && (r_in_mv >= r_zero_mv));

    // Saturating run counters: stop at the run length or at all ones
    assign good_inc = ((CW'(r_good_run) < CW'(r_ready_run_len)) && (r_good_run != RUN_MAX))
                      ? r_good_run + RW'(1) : r_good_run;
    assign bad_inc  = ((CW'(r_bad_run) < CW'(r_lost_run_len)) && (r_bad_run != RUN_MAX))
                      ? r_bad_run + RW'(1) : r_bad_run;

    always_comb begin
        n_mode     = r_mode;
        n_good_run = r_good_run;
        n_bad_run  = r_bad_run;
        n_pct      = r_pct;
        if (r_in_cmd == CMD_FALLBACK) begin
            if (r_mode != ST_READY) begin
                n_mode     = ST_FALLBACK;
                n_good_run = '0;
                n_bad_run  = '0;
            end
        end else if (r_mode == ST_READY) begin
            if (reading_ok) begin
                n_bad_run = '0;
                n_pct     = in_pct;
            end else if (CW'(bad_inc) >= CW'(r_lost_run_len)) begin
                n_mode     = ST_FALLBACK;
                n_pct      = PCT_NONE;
                n_good_run = '0;
                n_bad_run  = '0;
            end else begin
                n_bad_run = bad_inc;
            end
        end else begin
            if (!reading_ok) begin
                n_good_run = '0;
            end else if (CW'(good_inc) >= CW'(r_ready_run_len)) begin
                n_mode     = ST_READY;
                n_pct      = in_pct;
                n_good_run = '0;
                n_bad_run  = '0;
            end else begin
                n_good_run = good_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ST_WAIT;
            r_good_run <= '0;
            r_bad_run  <= '0;
            r_pct      <= PCT_NONE;
        end else if (step) begin
            r_mode     <= n_mode;
            r_good_run <= n_good_run;
            r_bad_run  <= n_bad_run;
            r_pct      <= n_pct;
        end
    end

    // Result register
    logic [MODE_W-1:0] r_out_mode;
    logic [PCT_W-1:0]  r_out_pct;
    logic              r_out_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_mode    <= mode_code(n_mode);
            r_out_pct     <= (n_mode == ST_READY) ? n_pct : PCT_NONE;
            r_out_changed <= (n_mode != r_mode) || (n_pct != r_pct);
        end
    end

    assign m_axis_tdata = {5'b0, r_out_changed, r_out_pct, r_out_mode};

    `BCRQ_ASSERT_NOW(a_shown_only_ready, i_clk, i_rst_n,
        r_out_valid && (r_out_mode != GM_READY), r_out_pct == PCT_NONE,
        "percent shown outside ready")
    `BCRQ_ASSERT_NOW(a_ready_pct_range, i_clk, i_rst_n,
        r_mode == ST_READY, (r_pct <= PCT_MAX) && (r_good_run == '0),
        "ready state with bad percent or nonzero good run")
    `BCRQ_ASSERT_NEXT(a_in_held_on_stall, i_clk, i_rst_n,
        r_in_valid && !advance, r_in_valid && $stable(r_in_word) && $stable(r_mode),
        "input stage lost or state moved while stalled")

endmodule
